[hw/rtl/energy_vad_endpointer_macros.svh]
// Assertion shorthands for the checker file.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ENERGY_VAD_ENDPOINTER_MACROS_SVH
`define ENERGY_VAD_ENDPOINTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define EVAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EVAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/evad_pkg.sv]
`default_nettype none

package evad_pkg;

    // Longest buffer the sample counter supports
    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = IDX_W + 1;

    // Field widths
    localparam int PCM_W  = 16;
    localparam int SQ_W   = 31;
    localparam int SUM_W  = 41;
    localparam int TIME_W = 20;
    localparam int FPB_W  = 11;
    localparam int MSB_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SUM_W;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // End reason codes
    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_SILENCE = 2'd1;
    localparam logic [1:0] REASON_MAX_LEN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BUFFER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MS_PER_BUFFER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ENERGY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ENERGY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_HANG_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HANG_MS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_UTTERANCE_MS  = 3'd6;

    // Register reset values
    localparam logic [FPB_W-1:0]  RST_FRAMES_PER_BUFFER = 11'd256;
    localparam logic [MSB_W-1:0]  RST_MS_PER_BUFFER     = 10'd16;
    localparam logic [SUM_W-1:0]  RST_START_ENERGY      = 41'd2748779069;
    localparam logic [SUM_W-1:0]  RST_STOP_ENERGY       = 41'd687194767;
    localparam logic [TIME_W-1:0] RST_START_HANG_MS     = 20'd100;
    localparam logic [TIME_W-1:0] RST_STOP_HANG_MS      = 20'd800;
    localparam logic [TIME_W-1:0] RST_MAX_UTTERANCE_MS  = 20'd10000;

    typedef struct packed {
        logic [FPB_W-1:0]  frames_per_buffer;
        logic [MSB_W-1:0]  ms_per_buffer;
        logic [SUM_W-1:0]  start_energy;
        logic [SUM_W-1:0]  stop_energy;
        logic [TIME_W-1:0] start_hang_ms;
        logic [TIME_W-1:0] stop_hang_ms;
        logic [TIME_W-1:0] max_utterance_ms;
    } cfg_t;

    // Squared sample travelling from the square stage to the decision stage
    typedef struct packed {
        logic            cmd;
        logic [SQ_W-1:0] sq;
    } sq_item_t;

    typedef struct packed {
        logic       buffer_end;
        logic       listening;
        logic       started;
        logic       finished;
        logic [1:0] end_reason;
    } result_t;

    // Saturating millisecond add
    function automatic logic [TIME_W-1:0] sat_time_add(input logic [TIME_W-1:0] t,
                                                       input logic [MSB_W-1:0]  ms);
        logic [TIME_W:0] s;
        s = {1'b0, t} + (TIME_W+1)'(ms);
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/evad_if.sv]
`default_nettype none

// Sample and restart command channel
interface evad_in_if import evad_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [PCM_W-1:0] pcm_sample;

    modport source (output valid, output cmd, output pcm_sample, input ready);
    modport sink   (input valid, input cmd, input pcm_sample, output ready);
endinterface

// Per-item decision channel
interface evad_out_if ();
    logic       valid;
    logic       ready;
    logic       buffer_end;
    logic       listening;
    logic       started;
    logic       finished;
    logic [1:0] end_reason;

    modport source (output valid, output buffer_end, output listening, output started,
                    output finished, output end_reason, input ready);
    modport sink   (input valid, input buffer_end, input listening, input started,
                    input finished, input end_reason, output ready);
endinterface

// Register write channel
interface evad_cfg_if import evad_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/evad_regs.sv]
`default_nettype none

module evad_regs import evad_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    evad_cfg_if.sink         cfg,
    output cfg_t             regs
);

    cfg_t regs_reg;

    // Writes are always accepted
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the write transfer; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.frames_per_buffer <= RST_FRAMES_PER_BUFFER;
            regs_reg.ms_per_buffer     <= RST_MS_PER_BUFFER;
            regs_reg.start_energy      <= RST_START_ENERGY;
            regs_reg.stop_energy       <= RST_STOP_ENERGY;
            regs_reg.start_hang_ms     <= RST_START_HANG_MS;
            regs_reg.stop_hang_ms      <= RST_STOP_HANG_MS;
            regs_reg.max_utterance_ms  <= RST_MAX_UTTERANCE_MS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAMES_PER_BUFFER: regs_reg.frames_per_buffer <= cfg.data[FPB_W-1:0];
                REG_MS_PER_BUFFER:     regs_reg.ms_per_buffer     <= cfg.data[MSB_W-1:0];
                REG_START_ENERGY:      regs_reg.start_energy      <= cfg.data[SUM_W-1:0];
                REG_STOP_ENERGY:       regs_reg.stop_energy       <= cfg.data[SUM_W-1:0];
                REG_START_HANG_MS:     regs_reg.start_hang_ms     <= cfg.data[TIME_W-1:0];
                REG_STOP_HANG_MS:      regs_reg.stop_hang_ms      <= cfg.data[TIME_W-1:0];
                REG_MAX_UTTERANCE_MS:  regs_reg.max_utterance_ms  <= cfg.data[TIME_W-1:0];
                default:               ;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/evad_square.sv]
`default_nettype none

module evad_square import evad_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    evad_in_if.sink    samples,
    input  wire logic  down_ready,
    output logic       item_valid,
    output sq_item_t   item
);

    logic                    in_v_reg;
    logic                    in_cmd_reg;
    logic signed [PCM_W-1:0] in_pcm_reg;
    logic                    sq_v_reg;
    sq_item_t                sq_item_reg;

    logic                    sq_free;
    logic                    in_free;
    logic signed [2*PCM_W-1:0] product;

    // A stage may load when empty or when its content moves on this cycle
    assign sq_free       = !sq_v_reg || down_ready;
    assign in_free       = !in_v_reg || sq_free;
    assign samples.ready = in_free;

    assign product    = in_pcm_reg * in_pcm_reg;
    assign item_valid = sq_v_reg;
    assign item       = sq_item_reg;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_v_reg <= samples.valid;
            end
            if (sq_free)
            begin
                sq_v_reg <= in_v_reg;
            end
        end
    end

    // Capture the input transfer, then square it
    always_ff @(posedge clk)
    begin
        if (in_free && samples.valid)
        begin
            in_cmd_reg <= samples.cmd;
            in_pcm_reg <= samples.pcm_sample;
        end
        if (sq_free && in_v_reg)
        begin
            sq_item_reg.cmd <= in_cmd_reg;
            sq_item_reg.sq  <= product[SQ_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/evad_decide.sv]
`default_nettype none

module evad_decide import evad_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cfg_t       regs,
    input  wire logic  item_valid,
    input  sq_item_t   item,
    output logic       down_ready,
    evad_out_if.source results
);

    logic [IDX_W-1:0]  idx_reg,       idx_next;
    logic [SUM_W-1:0]  sum_reg,       sum_next;
    logic [TIME_W-1:0] speech_reg,    speech_next;
    logic [TIME_W-1:0] silence_reg,   silence_next;
    logic [TIME_W-1:0] total_reg,     total_next;
    logic              listen_reg,    listen_next;
    logic              finished_reg,  finished_next;
    logic [1:0]        reason_reg,    reason_next;
    logic              out_v_reg;
    result_t           res_reg,       res_next;

    logic              take;
    logic [FPB_W-1:0]  frames_eff;
    logic [CNT_W-1:0]  idx_inc;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic              bend;
    logic [TIME_W-1:0] speech_add;
    logic [TIME_W-1:0] silence_add;
    logic              done;

    assign down_ready = !out_v_reg || results.ready;
    assign take       = item_valid && down_ready;

    // Clamp the buffer length into the counter's range
    always_comb
    begin
        priority if (regs.frames_per_buffer == '0)
            frames_eff = FPB_W'(1);
        else if (32'(regs.frames_per_buffer) > MAX_FRAMES)
            frames_eff = FPB_W'(MAX_FRAMES);
        else
            frames_eff = regs.frames_per_buffer;
    end

    // Accumulate with saturation and detect the end of a buffer
    assign idx_inc  = {1'b0, idx_reg} + CNT_W'(1);
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(item.sq);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign bend     = 32'(idx_inc) >= 32'(frames_eff);

    assign speech_add  = sat_time_add(speech_reg, regs.ms_per_buffer);
    assign silence_add = sat_time_add(silence_reg, regs.ms_per_buffer);

    // Next state and result for the item at the head of the pipeline
    always_comb
    begin
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        speech_next   = speech_reg;
        silence_next  = silence_reg;
        total_next    = total_reg;
        listen_next   = listen_reg;
        finished_next = finished_reg;
        reason_next   = reason_reg;
        done          = 1'b0;
        res_next      = '0;

        priority if (item.cmd == CMD_RESTART)
        begin
            idx_next      = '0;
            sum_next      = '0;
            speech_next   = '0;
            silence_next  = '0;
            total_next    = '0;
            listen_next   = 1'b0;
            finished_next = 1'b0;
            reason_next   = REASON_NONE;
        end
        else if (finished_reg)
        begin
            res_next.finished   = 1'b1;
            res_next.end_reason = reason_reg;
        end
        else
        begin
            if (!bend)
            begin
                idx_next = idx_inc[IDX_W-1:0];
                sum_next = sum_sat;
            end
            else
            begin
                idx_next   = '0;
                sum_next   = '0;
                total_next = sat_time_add(total_reg, regs.ms_per_buffer);
                res_next.buffer_end = 1'b1;

                if (!listen_reg)
                begin
                    // Count loud time until the start hang is reached
                    if (sum_sat >= regs.start_energy)
                    begin
                        speech_next = speech_add;
                        if (speech_add >= regs.start_hang_ms)
                        begin
                            listen_next      = 1'b1;
                            res_next.started = 1'b1;
                            silence_next     = '0;
                        end
                    end
                    else
                    begin
                        speech_next = '0;
                    end
                end
                else
                begin
                    // Count quiet time; the stop hang wins over the length limit
                    if (sum_sat <= regs.stop_energy)
                    begin
                        silence_next = silence_add;
                        if (silence_add >= regs.stop_hang_ms)
                        begin
                            done        = 1'b1;
                            reason_next = REASON_SILENCE;
                        end
                    end
                    else
                    begin
                        silence_next = '0;
                    end
                    if (!done && total_next >= regs.max_utterance_ms)
                    begin
                        done        = 1'b1;
                        reason_next = REASON_MAX_LEN;
                    end
                    if (done)
                    begin
                        finished_next = 1'b1;
                        listen_next   = 1'b0;
                    end
                end
            end
            res_next.listening  = listen_next;
            res_next.finished   = finished_next;
            res_next.end_reason = reason_next;
        end
    end

    // Endpointer state advances once per item taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            sum_reg      <= '0;
            speech_reg   <= '0;
            silence_reg  <= '0;
            total_reg    <= '0;
            listen_reg   <= 1'b0;
            finished_reg <= 1'b0;
            reason_reg   <= REASON_NONE;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                idx_reg      <= idx_next;
                sum_reg      <= sum_next;
                speech_reg   <= speech_next;
                silence_reg  <= silence_next;
                total_reg    <= total_next;
                listen_reg   <= listen_next;
                finished_reg <= finished_next;
                reason_reg   <= reason_next;
            end
            if (down_ready)
            begin
                out_v_reg <= item_valid;
            end
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid      = out_v_reg;
    assign results.buffer_end = res_reg.buffer_end;
    assign results.listening  = res_reg.listening;
    assign results.started    = res_reg.started;
    assign results.finished   = res_reg.finished;
    assign results.end_reason = res_reg.end_reason;

endmodule

`default_nettype wire

[hw/rtl/energy_vad_endpointer.sv]
// Energy-based voice activity endpointer.
//
// samples: one transfer per PCM sample (cmd sample) or restart (cmd restart).
// results: exactly one transfer per input transfer, in order: buffer_end,
//   listening, started, finished and end_reason after that item.
// cfg: register writes, index and data, always ready; write only while idle.
//
// Pipeline: an input transfer loads the input register, its square then the
// square register and its result then the result register, which drives
// results. Throughput: one item per cycle while results.ready is high. The
// single 16x16 squarer sits in the square stage and the 41-bit
// accumulate-and-compare in the decision stage.
//
// Reset clears all endpointer state and loads the register defaults; no
// result is pending afterwards. A restart item clears the state but keeps
// the registers. When results.ready stays low, up to three items are held
// in the pipeline, then samples.ready drops until the result is taken.
`default_nettype none

module energy_vad_endpointer import evad_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    evad_in_if.sink     samples,
    evad_out_if.source  results,
    evad_cfg_if.sink    cfg
);

    cfg_t     regs;
    logic     item_valid;
    sq_item_t item;
    logic     down_ready;

    // Register file
    evad_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Input capture and squaring
    evad_square u_square (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .down_ready (down_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // Accumulation, decision and result register
    evad_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .item_valid (item_valid),
        .item       (item),
        .down_ready (down_ready),
        .results    (results)
    );

endmodule

`default_nettype wire

[hw/rtl/evad_checker.sv]
`default_nettype none
`include "energy_vad_endpointer_macros.svh"

module evad_checker import evad_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       buffer_end,
    input wire logic       listening,
    input wire logic       started,
    input wire logic       finished,
    input wire logic [1:0] end_reason
);

    // A start is reported only on a decision buffer that opens listening
    `EVAD_ASSERT_NOW(a_started_consistent, out_valid && started, buffer_end && listening && !finished, "started without an open utterance")

    // A finished utterance carries a real reason and is no longer listening
    `EVAD_ASSERT_NOW(a_finished_reason, out_valid && finished, !listening && (end_reason == REASON_SILENCE || end_reason == REASON_MAX_LEN), "finished with bad reason or still listening")

    // Until finished, no end reason may show
    `EVAD_ASSERT_NOW(a_reason_only_when_done, out_valid && !finished, end_reason == REASON_NONE, "end reason set before the utterance ended")

    // A stalled result holds its payload
    `EVAD_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(buffer_end) && $stable(listening) && $stable(started) && $stable(finished) && $stable(end_reason), "stalled result changed")

endmodule

bind energy_vad_endpointer evad_checker u_evad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .buffer_end (results.buffer_end),
    .listening  (results.listening),
    .started    (results.started),
    .finished   (results.finished),
    .end_reason (results.end_reason)
);

`default_nettype wire
